### src/fccc_pkg.sv
// ----------------------------------------------------------------------------
// Flash cartridge command controller package
// Shared types, command codes and ROM size helpers for the controller.
// ----------------------------------------------------------------------------
`default_nettype none

package fccc_pkg;

  // Field widths
  localparam int unsigned RomAddrW = 19;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgFlashEnable = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgRomSize     = 1'b1;

  // ROM size codes
  localparam logic [1:0] RomSize128K = 2'd0;
  localparam logic [1:0] RomSize256K = 2'd1;
  localparam logic [1:0] RomSize512K = 2'd2;

  // Unlock sequence
  localparam logic [RomAddrW-1:0] UnlockAddr1 = 19'h05555;
  localparam logic [7:0]          UnlockData1 = 8'hAA;
  localparam logic [RomAddrW-1:0] UnlockAddr2 = 19'h02AAA;
  localparam logic [7:0]          UnlockData2 = 8'h55;

  // Command bytes
  localparam logic [7:0] CmdErase   = 8'h80;
  localparam logic [7:0] CmdProgram = 8'hA0;
  localparam logic [7:0] CmdIdEntry = 8'h90;
  localparam logic [7:0] CmdIdExit  = 8'hF0;

  // Software-ID bytes
  localparam logic [7:0] ManufId      = 8'hBF;
  localparam logic [7:0] DevId128K    = 8'hB5;
  localparam logic [7:0] DevId256K    = 8'hB6;
  localparam logic [7:0] DevId512K    = 8'hB7;
  localparam logic [7:0] DevIdUnknown = 8'hFF;

  // Result action codes
  typedef enum logic [2:0] {
    ActNone    = 3'd0,
    ActBank    = 3'd1,
    ActProgram = 3'd2,
    ActErase   = 3'd3,
    ActIdRead  = 3'd4
  } action_e;

  // Command sequencer steps; codes six and seven are unused
  typedef enum logic [2:0] {
    StIdle    = 3'd0,
    StUnlock1 = 3'd1,
    StCmd     = 3'd2,
    StArg     = 3'd3,
    StUnlock2 = 3'd4,
    StErase   = 3'd5
  } step_e;

  // One CPU bus access
  typedef struct packed {
    logic        kind;
    logic [15:0] cpu_address;
    logic [7:0]  bus_data;
  } in_item_t;

  // One result
  typedef struct packed {
    action_e             action;
    logic [RomAddrW-1:0] flash_address;
    logic [7:0]          write_data;
    logic [7:0]          read_data;
    logic [4:0]          prg_bank;
    logic [1:0]          chr_bank;
    logic                mirror_select;
    logic                id_mode;
  } out_item_t;

  // Address mask for the fitted ROM size; size code three acts as 512K.
  function automatic logic [RomAddrW-1:0] size_mask(input logic [1:0] code);
    logic [RomAddrW-1:0] mask;
    case (code)
      RomSize128K: mask = 19'h1FFFF;
      RomSize256K: mask = 19'h3FFFF;
      default:     mask = 19'h7FFFF;
    endcase
    return mask;
  endfunction

  // Device byte reported in software-ID mode.
  function automatic logic [7:0] device_byte(input logic [1:0] code);
    logic [7:0] id;
    case (code)
      RomSize128K: id = DevId128K;
      RomSize256K: id = DevId256K;
      RomSize512K: id = DevId512K;
      default:     id = DevIdUnknown;
    endcase
    return id;
  endfunction

endpackage

`default_nettype wire

### src/flash_cart_command_controller_top.sv
// ----------------------------------------------------------------------------
// Flash cartridge command controller, top level
// Bank register and flash command sequencer for a cartridge bus.
// ----------------------------------------------------------------------------
// The block takes one CPU bus access per clock cycle while neither side stalls
// and returns exactly one result for each. An access passes through an input
// register and the command logic into a result register, and a new access can
// follow in every cycle unless the result register is held; the bank register
// and command step are updated once for each access.
// Writes to the configuration registers take effect at once and should be
// made while no access is in flight.
`default_nettype none

module flash_cart_command_controller_top
  import fccc_pkg::*;
#(
  parameter int unsigned SECTOR_BYTES = 4096
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire in_item_t            in_item_i,
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      out_item_t           out_item_o
);

  logic      s1_valid;
  in_item_t  s1_item;
  logic      advance;
  out_item_t result;

  // Input register
  fccc_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .advance_i  (advance),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  // Command logic
  fccc_core #(
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (s1_valid && advance),
    .item_i      (s1_item),
    .result_o    (result)
  );

  // Result register
  fccc_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (s1_valid),
    .res_item_i  (result),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

### src/fccc_in_stage.sv
// ----------------------------------------------------------------------------
// Input register
// Holds one accepted bus access until the command logic has handled it.
// ----------------------------------------------------------------------------
`default_nettype none

module fccc_in_stage
  import fccc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output      logic     in_stall_o,
  input  wire in_item_t in_item_i,
  input  wire logic     advance_i,
  output      logic     valid_o,
  output      in_item_t item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     load;

  // The register is busy only while its item cannot move on.
  assign in_stall_o = valid_q && !advance_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

### src/fccc_core.sv
// ----------------------------------------------------------------------------
// Command logic
// Bank register, unlock and command sequencer, software-ID mode and the
// configuration registers; forms the result of the registered bus access.
// ----------------------------------------------------------------------------
`default_nettype none

module fccc_core
  import fccc_pkg::*;
#(
  parameter int unsigned SECTOR_BYTES = 4096
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                fire_i,
  input  wire in_item_t            item_i,
  output      out_item_t           result_o
);

  localparam logic [RomAddrW-1:0] SectorMask = ~(RomAddrW'(SECTOR_BYTES - 1));

  logic        flash_en_q;
  logic [1:0]  rom_size_q;
  logic [7:0]  bank_q, bank_d;
  step_e       step_q, step_d;
  logic [7:0]  code_q, code_d;
  logic        id_q, id_d;

  logic                selected;
  logic                is_read;
  logic                bank_wr;
  logic                cmd_wr;
  logic [7:0]          data;
  logic [RomAddrW-1:0] faddr;
  logic [RomAddrW-1:0] raddr;

  // Decode of the access
  assign selected = item_i.cpu_address[15];
  assign is_read  = item_i.kind;
  assign data     = item_i.bus_data;
  assign bank_wr  = selected && !is_read && (item_i.cpu_address[14] || !flash_en_q);
  assign cmd_wr   = selected && !is_read && !bank_wr;

  // Flash address from the CPU window and the PRG bank; bit 14 overlaps.
  assign faddr = {bank_q[4:0], 14'd0} | {4'd0, item_i.cpu_address[14:0]};
  assign raddr = faddr & size_mask(rom_size_q);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flash_en_q <= 1'b1;
      rom_size_q <= RomSize512K;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgFlashEnable: flash_en_q <= cfg_wdata_i[0];
        CfgRomSize:     rom_size_q <= cfg_wdata_i;
        default:        ;
      endcase
    end
  end

  // Next state of the bank register and the command sequencer
  always_comb begin
    bank_d = bank_q;
    step_d = step_q;
    code_d = code_q;
    id_d   = id_q;
    if (fire_i && bank_wr) begin
      bank_d = data;
    end else if (fire_i && cmd_wr) begin
      case (step_q)
        StIdle: begin
          if (faddr == UnlockAddr1 && data == UnlockData1) begin
            step_d = StUnlock1;
          end else if (data == CmdIdExit) begin
            id_d = 1'b0;
          end
        end
        StUnlock1, StUnlock2: begin
          if (faddr == UnlockAddr2 && data == UnlockData2) begin
            step_d = (step_q == StUnlock1) ? StCmd : StErase;
          end else begin
            step_d = StIdle;
          end
        end
        StCmd: begin
          if (data inside {CmdErase, CmdProgram, CmdIdEntry, CmdIdExit}) begin
            code_d = data;
            step_d = StArg;
            if (data == CmdIdEntry) begin
              id_d = 1'b1;
            end else if (data == CmdIdExit) begin
              id_d = 1'b0;
            end
          end else begin
            step_d = StIdle;
          end
        end
        StArg: begin
          if (code_q != CmdProgram && code_q == CmdErase && data == UnlockData1) begin
            step_d = StUnlock2;
          end else begin
            step_d = StIdle;
          end
        end
        default: begin
          step_d = StIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q <= 8'd0;
      step_q <= StIdle;
      code_q <= 8'd0;
      id_q   <= 1'b0;
    end else begin
      bank_q <= bank_d;
      step_q <= step_d;
      code_q <= code_d;
      id_q   <= id_d;
    end
  end

  // Result of the access; status fields show the state after it.
  always_comb begin
    result_o               = '0;
    result_o.action        = ActNone;
    result_o.prg_bank      = bank_d[4:0];
    result_o.chr_bank      = bank_d[6:5];
    result_o.mirror_select = bank_d[7];
    result_o.id_mode       = id_d;
    if (selected && is_read) begin
      if (id_q) begin
        result_o.action    = ActIdRead;
        result_o.read_data = item_i.cpu_address[0] ? device_byte(rom_size_q) : ManufId;
      end
    end else if (bank_wr) begin
      result_o.action = ActBank;
    end else if (cmd_wr) begin
      if (step_q == StArg && code_q == CmdProgram) begin
        result_o.action        = ActProgram;
        result_o.flash_address = raddr;
        result_o.write_data    = data;
      end else if (step_q == StErase) begin
        result_o.action        = ActErase;
        result_o.flash_address = raddr & SectorMask;
      end
    end
  end

  // An erase is only issued from the final step of the erase sequence.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && result_o.action == ActErase |-> step_q == StErase)
    else $error("erase issued outside the erase step");

  // A program transfer always returns the sequencer to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && result_o.action == ActProgram |=> step_q == StIdle)
    else $error("sequencer not idle after byte program");

  // Software-ID mode is only entered from the command step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(id_q) |-> $past(step_q) == StCmd)
    else $error("ID mode entered outside the command step");

  // Bank register writes leave the command sequence undisturbed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && bank_wr |=> $stable(step_q))
    else $error("bank write disturbed the command step");

endmodule

`default_nettype wire

### src/fccc_out_stage.sv
// ----------------------------------------------------------------------------
// Result register
// Holds one result until the receiving side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module fccc_out_stage
  import fccc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      res_valid_i,
  input  wire out_item_t res_item_i,
  output      logic      advance_o,
  output      logic      out_valid_o,
  input  wire logic      out_stall_i,
  output      out_item_t out_item_o
);

  logic      valid_q, valid_d;
  out_item_t item_q;

  // The register can take a new result when empty or being emptied.
  assign advance_o = !valid_q || !out_stall_i;
  assign valid_d   = advance_o ? res_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && res_valid_i) begin
      item_q <= res_item_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

`default_nettype wire

### tb/cart_check_pkg.sv
// ----------------------------------------------------------------------------
// Flash cartridge command controller result checker
// Tracks the bank register, the command sequencer and software-ID mode, and
// holds the result each accepted bus access should produce, in order.
// ----------------------------------------------------------------------------

package cart_check_pkg;

  import fccc_pkg::*;

  // Bus access kinds
  localparam logic KindWrite = 1'b0;
  localparam logic KindRead  = 1'b1;

  // Flash enable register values and the spare size code
  localparam logic       FlashOff     = 1'b0;
  localparam logic       FlashOn      = 1'b1;
  localparam logic [1:0] RomSizeSpare = 2'd3;

  // Writes from this address upwards always load the bank register.
  localparam logic [15:0] BankWindow = 16'hC000;

  localparam int unsigned         SectorBytes = 4096;
  localparam logic [RomAddrW-1:0] SectorMask  = ~(RomAddrW'(SectorBytes - 1));

  // Only the first ten mismatches are printed; later ones are only counted.
  localparam int unsigned ReportLimit = 10;

  class cart_checker;

    logic                flash_on;
    logic [1:0]          size_code;
    logic [7:0]          bank_reg;
    step_e               step;
    logic [7:0]          cmd_byte;
    logic                id_on;
    out_item_t           pending_results[$];
    int unsigned         mismatches;

    function new();
      flash_on   = FlashOn;
      size_code  = RomSize512K;
      bank_reg   = '0;
      step       = StIdle;
      cmd_byte   = '0;
      id_on      = 1'b0;
      mismatches = 0;
    endfunction

    function void write_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
      if (idx == CfgFlashEnable) begin
        flash_on = value[0];
      end else begin
        size_code = value;
      end
    endfunction

    // Address mask for the fitted ROM; the spare code behaves as the largest size.
    function logic [RomAddrW-1:0] rom_mask();
      case (size_code)
        RomSize128K: return 19'h1FFFF;
        RomSize256K: return 19'h3FFFF;
        default:     return 19'h7FFFF;
      endcase
    endfunction

    function logic [7:0] device_id();
      case (size_code)
        RomSize128K: return DevId128K;
        RomSize256K: return DevId256K;
        RomSize512K: return DevId512K;
        default:     return DevIdUnknown;
      endcase
    endfunction

    // Works out the result of one bus access and advances the tracked state.
    function out_item_t predict_result(in_item_t acc);
      out_item_t           res;
      logic [RomAddrW-1:0] flash_addr;
      logic [RomAddrW-1:0] rom_addr;
      res        = '0;
      flash_addr = {bank_reg[4:0], 14'd0} | {4'd0, acc.cpu_address[14:0]};
      rom_addr   = flash_addr & rom_mask();
      // With address bit 15 clear the cartridge is not selected at all.
      if (acc.cpu_address[15]) begin
        if (acc.kind == KindRead) begin
          // Ordinary reads are served by the ROM itself; only ID mode answers here.
          if (id_on) begin
            res.action    = ActIdRead;
            res.read_data = acc.cpu_address[0] ? device_id() : ManufId;
          end
        end else if (acc.cpu_address >= BankWindow || !flash_on) begin
          bank_reg   = acc.bus_data;
          res.action = ActBank;
        end else begin
          case (step)
            StIdle: begin
              if (flash_addr == UnlockAddr1 && acc.bus_data == UnlockData1) begin
                step = StUnlock1;
              end else if (acc.bus_data == CmdIdExit) begin
                id_on = 1'b0;
              end
            end
            StUnlock1, StUnlock2: begin
              if (flash_addr == UnlockAddr2 && acc.bus_data == UnlockData2) begin
                step = (step == StUnlock1) ? StCmd : StErase;
              end else begin
                step = StIdle;
              end
            end
            StCmd: begin
              if (acc.bus_data inside {CmdErase, CmdProgram, CmdIdEntry, CmdIdExit}) begin
                cmd_byte = acc.bus_data;
                step     = StArg;
                if (acc.bus_data == CmdIdEntry) begin
                  id_on = 1'b1;
                end else if (acc.bus_data == CmdIdExit) begin
                  id_on = 1'b0;
                end
              end else begin
                step = StIdle;
              end
            end
            StArg: begin
              if (cmd_byte == CmdProgram) begin
                res.action        = ActProgram;
                res.flash_address = rom_addr;
                res.write_data    = acc.bus_data;
                step              = StIdle;
              end else if (cmd_byte == CmdErase && acc.bus_data == UnlockData1) begin
                step = StUnlock2;
              end else begin
                step = StIdle;
              end
            end
            StErase: begin
              // Any address and data finish the erase of the enclosing sector.
              res.action        = ActErase;
              res.flash_address = rom_addr & SectorMask;
              step              = StIdle;
            end
            default: begin
              step = StIdle;
            end
          endcase
        end
      end
      res.prg_bank      = bank_reg[4:0];
      res.chr_bank      = bank_reg[6:5];
      res.mirror_select = bank_reg[7];
      res.id_mode       = id_on;
      return res;
    endfunction

    function void note_access(in_item_t acc);
      pending_results.push_back(predict_result(acc));
    endfunction

    function string show(out_item_t r);
      return $sformatf("act=%0d addr=%05h wdata=%02h rdata=%02h prg=%0d chr=%0d mirror=%0b id=%0b",
                       r.action, r.flash_address, r.write_data, r.read_data, r.prg_bank,
                       r.chr_bank, r.mirror_select, r.id_mode);
    endfunction

    // Compares one result transfer with the oldest outstanding prediction.
    function void check_result(out_item_t got);
      out_item_t want;
      logic      bad;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit) begin
          $display("result with nothing outstanding: %s", show(got));
        end
        return;
      end
      want = pending_results.pop_front();
      bad  = (got.action !== want.action) || (got.flash_address !== want.flash_address) ||
             (got.write_data !== want.write_data) || (got.read_data !== want.read_data) ||
             (got.prg_bank !== want.prg_bank) || (got.chr_bank !== want.chr_bank) ||
             (got.mirror_select !== want.mirror_select) || (got.id_mode !== want.id_mode);
      if (bad) begin
        mismatches++;
        if (mismatches <= ReportLimit) begin
          $display("mismatch: expected %s", show(want));
          $display("          actual   %s", show(got));
        end
      end
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction

  endclass

endpackage

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// Flash cartridge command controller testbench
// Drives bus accesses through directed and random command sequences under
// several register settings and idling patterns, and checks every result
// against a predicted copy of the bank register and command sequencer.
// ----------------------------------------------------------------------------

module tb_top;

  import fccc_pkg::*;
  import cart_check_pkg::*;

  localparam int unsigned QuietLimit  = 1000;
  localparam int unsigned HoldCycles  = 60;
  localparam int unsigned DrainCycles = 8;

  // Flash offsets and PRG banks that reach the two unlock addresses
  localparam logic [13:0] UnlockOffs1 = UnlockAddr1[13:0];
  localparam logic [4:0]  UnlockBank1 = UnlockAddr1[18:14];
  localparam logic [13:0] UnlockOffs2 = UnlockAddr2[13:0];
  localparam logic [4:0]  UnlockBank2 = UnlockAddr2[18:14];

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  in_item_t            in_item_i   = '0;
  logic                out_stall_i = 1'b0;
  logic                in_stall_o;
  logic                out_valid_o;
  out_item_t           out_item_o;

  cart_checker board = new();

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_count     = 0;
  int unsigned sent_items     = 0;
  int unsigned quiet_cycles   = 0;

  flash_cart_command_controller_top #(
    .SECTOR_BYTES(SectorBytes)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  // Clock with a period of 20 time units.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Monitor: predicts on each input transfer and checks each result transfer.
  always @(posedge clk_i) begin
    logic moved;
    moved = 1'b0;
    if (in_valid_i && !in_stall_o) begin
      board.note_access(in_item_i);
      moved = 1'b1;
    end
    if (out_valid_o && !out_stall_i) begin
      board.check_result(out_item_o);
      moved = 1'b1;
    end
    quiet_cycles <= moved ? 0 : quiet_cycles + 1;
  end

  // Watchdog: ends the run when nothing has moved for too long.
  initial begin
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("FAILURE");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  initial begin : receiver
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(negedge clk_i);
      if (hold_count != hold_seen) begin
        hold_seen = hold_count;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [13:0] any_offset();
    return 14'($urandom_range(16'h3FFF));
  endfunction

  // Bank register byte with the given PRG bank and random CHR and mirroring bits.
  function automatic logic [7:0] bank_byte(logic [4:0] prg);
    return {3'($urandom_range(7)), prg};
  endfunction

  // Offers one bus access after a random idle gap and waits for its transfer.
  // Called and returning at a falling edge.
  task automatic send_access(input logic kind, input logic [15:0] addr,
                             input logic [7:0] data);
    in_item_t acc;
    acc.kind        = kind;
    acc.cpu_address = addr;
    acc.bus_data    = data;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= acc;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    @(negedge clk_i);
    sent_items++;
  endtask

  task automatic write_bank(input logic [7:0] data);
    send_access(KindWrite, {2'b11, any_offset()}, data);
  endtask

  task automatic flash_write(input logic [13:0] offs, input logic [7:0] data);
    send_access(KindWrite, {2'b10, offs}, data);
  endtask

  // The two unlock cycles, with a bank switch before each to reach its address.
  task automatic unlock_cycle();
    write_bank(bank_byte(UnlockBank1));
    flash_write(UnlockOffs1, UnlockData1);
    write_bank(bank_byte(UnlockBank2));
    flash_write(UnlockOffs2, UnlockData2);
  endtask

  task automatic program_byte();
    unlock_cycle();
    flash_write(any_offset(), CmdProgram);
    if ($urandom_range(1) == 1) write_bank(any_byte());
    flash_write(any_offset(), any_byte());
  endtask

  task automatic erase_sector();
    unlock_cycle();
    flash_write(any_offset(), CmdErase);
    flash_write(any_offset(), UnlockData1);
    write_bank(bank_byte(UnlockBank2));
    flash_write(UnlockOffs2, UnlockData2);
    if ($urandom_range(1) == 1) write_bank(any_byte());
    flash_write(any_offset(), any_byte());
  endtask

  // Enters software-ID mode, reads a few bytes, then leaves it one of two ways or stays in it.
  task automatic id_session();
    int unsigned leave;
    leave = $urandom_range(2);
    unlock_cycle();
    flash_write(any_offset(), CmdIdEntry);
    repeat ($urandom_range(1, 4)) begin
      send_access(KindRead, 16'($urandom_range(16'h8000, 16'hFFFF)), any_byte());
    end
    if (leave == 0) begin
      // The first write closes the command; the exit byte then acts from idle.
      flash_write(any_offset(), any_byte());
      flash_write(any_offset(), CmdIdExit);
    end else if (leave == 1) begin
      unlock_cycle();
      flash_write(any_offset(), CmdIdExit);
      flash_write(any_offset(), any_byte());
    end
  endtask

  // An unlock with at most one flaw, followed by two arbitrary writes.
  task automatic mangled_unlock();
    int unsigned flaw;
    flaw = $urandom_range(4);
    write_bank(bank_byte(flaw == 1 ? 5'($urandom_range(31)) : UnlockBank1));
    flash_write(UnlockOffs1, flaw == 2 ? any_byte() : UnlockData1);
    write_bank(bank_byte(UnlockBank2));
    flash_write(flaw == 3 ? any_offset() : UnlockOffs2, flaw == 4 ? any_byte() : UnlockData2);
    flash_write(any_offset(), any_byte());
    flash_write(any_offset(), any_byte());
  endtask

  task automatic random_items(input int unsigned count);
    int unsigned target;
    int unsigned pick;
    target = sent_items + count;
    while (sent_items < target) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        program_byte();
      end else if (pick < 45) begin
        erase_sector();
      end else if (pick < 60) begin
        id_session();
      end else if (pick < 75) begin
        mangled_unlock();
      end else if (pick < 90) begin
        send_access(1'($urandom_range(1)), 16'($urandom), any_byte());
      end else begin
        write_bank(any_byte());
      end
    end
  endtask

  // Stops offering and waits until every predicted result has arrived.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.outstanding() != 0) @(negedge clk_i);
  endtask

  // Writes both configuration registers while the block is idle.
  task automatic apply_settings(input logic enable, input logic [1:0] size);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CfgFlashEnable;
    cfg_wdata_i <= {1'b0, enable};
    @(posedge clk_i);
    board.write_register(CfgFlashEnable, {1'b0, enable});
    @(negedge clk_i);
    cfg_index_i <= CfgRomSize;
    cfg_wdata_i <= size;
    @(posedge clk_i);
    board.write_register(CfgRomSize, size);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic directed_accesses();
    // Unselected accesses, a plain read and both extremes of the bank register.
    send_access(KindRead, 16'h8000, 8'h00);
    send_access(KindWrite, 16'h7FFF, 8'hFF);
    send_access(KindRead, 16'h0000, 8'hFF);
    send_access(KindWrite, 16'hFFFF, 8'hFF);
    send_access(KindWrite, 16'hC000, 8'h00);
    // An exit byte from idle outside ID mode is ignored.
    flash_write(14'h0000, CmdIdExit);
    // Program the very top byte of the flash.
    unlock_cycle();
    flash_write(14'h3FFF, CmdProgram);
    write_bank(8'h1F);
    flash_write(14'h3FFF, 8'hFF);
    // Software-ID entry, both ID bytes, then exit from idle.
    unlock_cycle();
    flash_write(14'h0000, CmdIdEntry);
    send_access(KindRead, 16'h8000, 8'h00);
    send_access(KindRead, 16'hFFFF, 8'h00);
    flash_write(14'h0000, CmdIdExit);
    flash_write(14'h0000, CmdIdExit);
  endtask

  // Main sequence: phases of settings and idling, then the verdict.
  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct  = 36;
    recv_stall_pct = 69;
    apply_settings(FlashOn, RomSize512K);
    directed_accesses();
    random_items(120);
    drain();
    apply_settings(FlashOn, RomSize128K);
    random_items(60);
    drain();

    send_idle_pct  = 69;
    recv_stall_pct = 36;
    apply_settings(FlashOff, RomSize256K);
    random_items(40);
    drain();
    apply_settings(FlashOn, RomSizeSpare);
    random_items(100);
    drain();

    // No idling; each phase opens with a long hold-off on the result side.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    apply_settings(FlashOn, RomSize256K);
    hold_count++;
    random_items(100);
    drain();
    apply_settings(FlashOn, RomSize512K);
    hold_count++;
    random_items(80);
    drain();

    repeat (DrainCycles) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### flash_cart_command_controller_top.f
src/fccc_pkg.sv
src/fccc_in_stage.sv
src/fccc_core.sv
src/fccc_out_stage.sv
src/flash_cart_command_controller_top.sv
tb/cart_check_pkg.sv
tb/tb_top.sv
